/* rtl/mfg_pkg.sv */
// Shared types and constants for the mesh face geometry block.
// Item structs, face kinds, controller commands and status.
// No dependencies.
package mfg_pkg;

   localparam int COORD_W        = 32;
   localparam int SUM_W          = 35;
   localparam int CNT_W          = 3;
   localparam int MAX_FACE_NODES = 4;
   localparam int SPACE_DIMS     = 3;
   localparam int PROD_W         = 64;
   localparam int HMAG_W         = 48;

   localparam logic [1:0] DIM_2D    = 2'd2;
   localparam logic [1:0] DIM_RESET = 2'd3;

   localparam logic [1:0] SHAPE_OK  = 2'd0;
   localparam logic [1:0] SHAPE_BAD = 2'd1;
   localparam logic [1:0] SHAPE_SAT = 2'd2;

   typedef struct packed {
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_y;
      logic signed [COORD_W-1:0] coord_z;
      logic                      last_node;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] center_x;
      logic signed [COORD_W-1:0] center_y;
      logic signed [COORD_W-1:0] center_z;
      logic [COORD_W-2:0]        area;
      logic signed [COORD_W-1:0] normal_x;
      logic signed [COORD_W-1:0] normal_y;
      logic signed [COORD_W-1:0] normal_z;
      logic [1:0]                shape_error;
   } rsp_type;

   typedef enum logic [1:0] {
      KIND_ERR,
      KIND_EDGE,
      KIND_TRI,
      KIND_QUAD
   } kind_type;

   typedef enum logic [3:0] {
      MUL_NONE,
      MUL_EDGE_X,
      MUL_EDGE_Y,
      MUL_P0,
      MUL_Q0,
      MUL_P1,
      MUL_Q1,
      MUL_P2,
      MUL_Q2,
      MUL_SQ0,
      MUL_SQ1,
      MUL_SQ2,
      MUL_QUAD
   } mul_op_type;

   typedef enum logic [2:0] {
      ACC_NONE,
      ACC_SS_LOAD,
      ACC_SS_ADD,
      ACC_CROSS_LOAD,
      ACC_CROSS_SUB,
      ACC_QUAD
   } acc_op_type;

   typedef struct packed {
      logic       busy;
      logic       prep;
      mul_op_type mul_op;
      acc_op_type acc_op;
      logic       cvt;
      logic [1:0] cvt_idx;
      logic       root_load;
      logic       div_step;
      logic       sqrt_step;
      logic       load_out;
   } cmd_type;

   typedef struct packed {
      logic     node_acc;
      logic     node_last;
      kind_type kind;
      logic     out_free;
   } status_type;

endpackage

/* rtl/mesh_face_geometry_top.sv */
// Mesh face geometry top level: handshakes, dimension register, result register.
// A node that is not the last one of its face is taken without a stall. A last node stalls
// the input for prep, k multiply steps (edge 3, triangle 10, quad 2), the root phase (load,
// then 35 divide steps with 32 square root steps alongside) and the result load; a bad face
// skips the multiply and root steps. The result load waits while the output is stalled.
// Synchronous active-high reset clears face, output, dim=3.
module mesh_face_geometry_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mfg_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mfg_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_data
);
   import mfg_pkg::*;

   cmd_type    cmd;
   status_type status;
   kind_type   kind;
   rsp_type    result;
   logic [1:0] dim_ff;
   logic       rsp_valid_ff;
   rsp_type    rsp_data_ff;

   assign req_stall        = cmd.busy;
   assign csr_ready        = 1'b1;
   assign status.node_acc  = req_valid && !cmd.busy;
   assign status.node_last = req_data.last_node;
   assign status.kind      = kind;
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   mfg_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   mfg_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .node_acc  (status.node_acc),
      .req       (req_data),
      .dimension (dim_ff),
      .kind      (kind),
      .result    (result)
   );

   // dimension register
   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff <= DIM_RESET;
      end else if (csr_valid && csr_ready) begin
         dim_ff <= csr_data;
      end
   end

   // hold the result item until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* rtl/mfg_ctrl.sv */
// Controller for the mesh face geometry block.
// Sequences prep, multiply, root/divide and result load. Uses mfg_pkg.
module mfg_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  mfg_pkg::status_type status,
   output mfg_pkg::cmd_type    cmd
);
   import mfg_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_PREP = 5'b00010,
      ST_MUL  = 5'b00100,
      ST_ROOT = 5'b01000,
      ST_FIN  = 5'b10000
   } state_type;

   localparam logic [3:0] LAST_EDGE = 4'd2;
   localparam logic [3:0] LAST_TRI  = 4'd9;
   localparam logic [3:0] LAST_QUAD = 4'd1;
   localparam logic [5:0] ROOT_LAST = 6'(SUM_W);
   localparam logic [5:0] SQRT_LAST = 6'(PROD_W / 2);

   state_type  state_ff, state_in;
   logic [3:0] step_ff, step_in;
   logic [5:0] iter_ff, iter_in;
   logic [3:0] step_last;

   // pick last multiply step for the face kind
   always_comb begin
      unique case (status.kind)
         KIND_EDGE: step_last = LAST_EDGE;
         KIND_TRI:  step_last = LAST_TRI;
         KIND_QUAD: step_last = LAST_QUAD;
         default:   step_last = '0;
      endcase
   end

   // next state and command decode
   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      iter_in       = iter_ff;
      cmd           = '0;
      cmd.mul_op    = MUL_NONE;
      cmd.acc_op    = ACC_NONE;
      cmd.busy      = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (status.node_acc && status.node_last) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            step_in  = '0;
            state_in = (status.kind == KIND_ERR) ? ST_FIN : ST_MUL;
         end
         ST_MUL: begin
            if (status.kind == KIND_EDGE) begin
               unique case (step_ff)
                  4'd0: cmd.mul_op = MUL_EDGE_X;
                  4'd1: begin
                     cmd.mul_op = MUL_EDGE_Y;
                     cmd.acc_op = ACC_SS_LOAD;
                  end
                  4'd2: cmd.acc_op = ACC_SS_ADD;
                  default: cmd.acc_op = ACC_NONE;
               endcase
            end else if (status.kind == KIND_TRI) begin
               unique case (step_ff)
                  4'd0: cmd.mul_op = MUL_P0;
                  4'd1: begin
                     cmd.mul_op = MUL_Q0;
                     cmd.acc_op = ACC_CROSS_LOAD;
                  end
                  4'd2: begin
                     cmd.mul_op = MUL_P1;
                     cmd.acc_op = ACC_CROSS_SUB;
                  end
                  4'd3: begin
                     cmd.mul_op  = MUL_Q1;
                     cmd.acc_op  = ACC_CROSS_LOAD;
                     cmd.cvt     = 1'b1;
                     cmd.cvt_idx = 2'd0;
                  end
                  4'd4: begin
                     cmd.mul_op = MUL_P2;
                     cmd.acc_op = ACC_CROSS_SUB;
                  end
                  4'd5: begin
                     cmd.mul_op  = MUL_Q2;
                     cmd.acc_op  = ACC_CROSS_LOAD;
                     cmd.cvt     = 1'b1;
                     cmd.cvt_idx = 2'd1;
                  end
                  4'd6: begin
                     cmd.mul_op = MUL_SQ0;
                     cmd.acc_op = ACC_CROSS_SUB;
                  end
                  4'd7: begin
                     cmd.mul_op  = MUL_SQ1;
                     cmd.acc_op  = ACC_SS_LOAD;
                     cmd.cvt     = 1'b1;
                     cmd.cvt_idx = 2'd2;
                  end
                  4'd8: begin
                     cmd.mul_op = MUL_SQ2;
                     cmd.acc_op = ACC_SS_ADD;
                  end
                  4'd9: cmd.acc_op = ACC_SS_ADD;
                  default: cmd.acc_op = ACC_NONE;
               endcase
            end else begin
               unique case (step_ff)
                  4'd0: cmd.mul_op = MUL_QUAD;
                  4'd1: cmd.acc_op = ACC_QUAD;
                  default: cmd.acc_op = ACC_NONE;
               endcase
            end
            if (step_ff == step_last) begin
               iter_in  = '0;
               state_in = ST_ROOT;
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         ST_ROOT: begin
            if (iter_ff == '0) begin
               cmd.root_load = 1'b1;
            end else begin
               cmd.div_step  = 1'b1;
               cmd.sqrt_step = (iter_ff <= SQRT_LAST);
            end
            if (iter_ff == ROOT_LAST) begin
               state_in = ST_FIN;
            end else begin
               iter_in = iter_ff + 6'd1;
            end
         end
         ST_FIN: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // advance state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         iter_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         iter_ff  <= iter_in;
      end
   end

endmodule

/* rtl/mfg_dp.sv */
// Datapath for the mesh face geometry block: node accumulation, shared
// multiplier, cross products, center divider, square root, result build.
// Uses mfg_pkg; driven by mfg_ctrl commands.
module mfg_dp (
   input  logic              clock,
   input  logic              reset,
   input  mfg_pkg::cmd_type   cmd,
   input  logic              node_acc,
   input  mfg_pkg::req_type   req,
   input  logic [1:0]        dimension,
   output mfg_pkg::kind_type  kind,
   output mfg_pkg::rsp_type   result
);
   import mfg_pkg::*;

   localparam logic [COORD_W-1:0] POS_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic [COORD_W-1:0] NEG_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   // saturate a sign and magnitude value to 32 bits; top bit flags saturation
   function automatic logic [COORD_W:0] sat_sm(input logic neg,
                                               input logic [HMAG_W-1:0] mag);
      logic [COORD_W:0] r;
      if (!neg) begin
         if (mag > HMAG_W'(POS_MAX)) r = {1'b1, POS_MAX};
         else r = {1'b0, mag[COORD_W-1:0]};
      end else begin
         if (mag > HMAG_W'(NEG_MIN)) r = {1'b1, NEG_MIN};
         else r = {1'b0, COORD_W'(0) - mag[COORD_W-1:0]};
      end
      return r;
   endfunction

   // face accumulation state
   logic [CNT_W-1:0]         count_ff, count_in;
   logic signed [SUM_W-1:0]  sum_ff [SPACE_DIMS];
   logic signed [SUM_W-1:0]  sum_in [SPACE_DIMS];
   logic signed [COORD_W-1:0] fn_ff [3][SPACE_DIMS];
   logic signed [COORD_W-1:0] fn_in [3][SPACE_DIMS];
   logic signed [COORD_W-1:0] bmin_ff [SPACE_DIMS];
   logic signed [COORD_W-1:0] bmin_in [SPACE_DIMS];
   logic signed [COORD_W-1:0] bmax_ff [SPACE_DIMS];
   logic signed [COORD_W-1:0] bmax_in [SPACE_DIMS];
   kind_type                 kind_ff, kind_in;
   logic signed [COORD_W-1:0] p [SPACE_DIMS];
   logic                     two_d;

   // prep registers
   logic [COORD_W-1:0] va_mag_ff [SPACE_DIMS];
   logic               va_neg_ff [SPACE_DIMS];
   logic [COORD_W-1:0] vb_mag_ff [SPACE_DIMS];
   logic               vb_neg_ff [SPACE_DIMS];
   logic [COORD_W-1:0] ext_ff [SPACE_DIMS];
   logic signed [COORD_W:0] da [SPACE_DIMS];
   logic signed [COORD_W:0] db [SPACE_DIMS];
   logic signed [COORD_W:0] de [SPACE_DIMS];

   // multiplier and accumulators
   logic [COORD_W-1:0]      mul_a, mul_b;
   logic                    mul_neg;
   logic [PROD_W-1:0]       prod_ff;
   logic                    prod_neg_ff;
   logic signed [PROD_W+1:0] prod_s;
   logic signed [PROD_W+1:0] cacc_ff;
   logic signed [PROD_W+1:0] d_ff;
   logic [PROD_W+1:0]       dmag;
   logic [HMAG_W-1:0]       h_mag_ff [SPACE_DIMS];
   logic                    h_neg_ff [SPACE_DIMS];
   logic [PROD_W-1:0]       ss_ff;
   logic [COORD_W-2:0]      quad_area_ff;
   logic                    quad_sat_ff;
   logic [SPACE_DIMS-1:0]   flat;

   // divider and square root
   logic [SUM_W-1:0]   q_ff [SPACE_DIMS];
   logic [1:0]         rem_ff [SPACE_DIMS];
   logic               s_neg_ff [SPACE_DIMS];
   logic [2:0]         dtmp [SPACE_DIMS];
   logic [PROD_W-1:0]  rad_ff;
   logic [33:0]        sq_rem_ff;
   logic [COORD_W-1:0] root_ff;
   logic [35:0]        rem2, trial;

   assign two_d = (dimension == DIM_2D);
   assign p[0]  = req.coord_x;
   assign p[1]  = req.coord_y;
   assign p[2]  = two_d ? '0 : req.coord_z;
   assign kind  = kind_ff;

   // accumulate an accepted node, classify the face on its last node
   always_comb begin
      count_in = count_ff;
      kind_in  = kind_ff;
      sum_in   = sum_ff;
      fn_in    = fn_ff;
      bmin_in  = bmin_ff;
      bmax_in  = bmax_ff;
      if (node_acc) begin
         if (count_ff < CNT_W'(MAX_FACE_NODES)) begin
            for (int j = 0; j < SPACE_DIMS; j++) begin
               sum_in[j] = sum_ff[j] + SUM_W'(p[j]);
               if (count_ff < CNT_W'(3)) fn_in[count_ff[1:0]][j] = p[j];
               if (count_ff == '0) begin
                  bmin_in[j] = p[j];
                  bmax_in[j] = p[j];
               end else begin
                  if (p[j] < bmin_ff[j]) bmin_in[j] = p[j];
                  if (p[j] > bmax_ff[j]) bmax_in[j] = p[j];
               end
            end
            count_in = count_ff + CNT_W'(1);
         end else begin
            count_in = CNT_W'(MAX_FACE_NODES + 1);
         end
         if (req.last_node) begin
            if (count_in > CNT_W'(MAX_FACE_NODES)) kind_in = KIND_ERR;
            else if (two_d) kind_in = (count_in == CNT_W'(2)) ? KIND_EDGE : KIND_ERR;
            else if (count_in == CNT_W'(3)) kind_in = KIND_TRI;
            else if (count_in == CNT_W'(4)) kind_in = KIND_QUAD;
            else kind_in = KIND_ERR;
         end
      end
      if (cmd.load_out) begin
         count_in = '0;
         for (int j = 0; j < SPACE_DIMS; j++) sum_in[j] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         kind_ff  <= KIND_ERR;
         for (int j = 0; j < SPACE_DIMS; j++) sum_ff[j] <= '0;
      end else begin
         count_ff <= count_in;
         kind_ff  <= kind_in;
         sum_ff   <= sum_in;
      end
   end

   // hold first nodes and bounding box
   always_ff @(posedge clock) begin
      fn_ff   <= fn_in;
      bmin_ff <= bmin_in;
      bmax_ff <= bmax_in;
   end

   // edge vectors and extents
   always_comb begin
      for (int j = 0; j < SPACE_DIMS; j++) begin
         da[j] = (COORD_W+1)'(fn_ff[1][j]) - (COORD_W+1)'(fn_ff[0][j]);
         db[j] = (COORD_W+1)'(fn_ff[2][j]) - (COORD_W+1)'(fn_ff[0][j]);
         de[j] = (COORD_W+1)'(bmax_ff[j]) - (COORD_W+1)'(bmin_ff[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         for (int j = 0; j < SPACE_DIMS; j++) begin
            va_neg_ff[j] <= da[j][COORD_W];
            va_mag_ff[j] <= da[j][COORD_W] ? COORD_W'(-da[j]) : da[j][COORD_W-1:0];
            vb_neg_ff[j] <= db[j][COORD_W];
            vb_mag_ff[j] <= db[j][COORD_W] ? COORD_W'(-db[j]) : db[j][COORD_W-1:0];
            ext_ff[j]    <= de[j][COORD_W-1:0];
         end
      end
   end

   for (genvar g = 0; g < SPACE_DIMS; g++) begin : g_flat
      assign flat[g] = (ext_ff[g] == '0);
   end

   // select multiplier operands
   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      mul_neg = 1'b0;
      case (cmd.mul_op)
         MUL_EDGE_X: begin mul_a = va_mag_ff[0]; mul_b = va_mag_ff[0]; end
         MUL_EDGE_Y: begin mul_a = va_mag_ff[1]; mul_b = va_mag_ff[1]; end
         MUL_P0: begin
            mul_a = va_mag_ff[1]; mul_b = vb_mag_ff[2]; mul_neg = va_neg_ff[1] ^ vb_neg_ff[2];
         end
         MUL_Q0: begin
            mul_a = va_mag_ff[2]; mul_b = vb_mag_ff[1]; mul_neg = va_neg_ff[2] ^ vb_neg_ff[1];
         end
         MUL_P1: begin
            mul_a = va_mag_ff[2]; mul_b = vb_mag_ff[0]; mul_neg = va_neg_ff[2] ^ vb_neg_ff[0];
         end
         MUL_Q1: begin
            mul_a = va_mag_ff[0]; mul_b = vb_mag_ff[2]; mul_neg = va_neg_ff[0] ^ vb_neg_ff[2];
         end
         MUL_P2: begin
            mul_a = va_mag_ff[0]; mul_b = vb_mag_ff[1]; mul_neg = va_neg_ff[0] ^ vb_neg_ff[1];
         end
         MUL_Q2: begin
            mul_a = va_mag_ff[1]; mul_b = vb_mag_ff[0]; mul_neg = va_neg_ff[1] ^ vb_neg_ff[0];
         end
         MUL_SQ0: begin
            mul_a = {1'b0, h_mag_ff[0][COORD_W-2:0]}; mul_b = mul_a;
         end
         MUL_SQ1: begin
            mul_a = {1'b0, h_mag_ff[1][COORD_W-2:0]}; mul_b = mul_a;
         end
         MUL_SQ2: begin
            mul_a = {1'b0, h_mag_ff[2][COORD_W-2:0]}; mul_b = mul_a;
         end
         MUL_QUAD: begin
            if (flat[0]) begin mul_a = ext_ff[1]; mul_b = ext_ff[2]; end
            else if (flat[1]) begin mul_a = ext_ff[2]; mul_b = ext_ff[0]; end
            else begin mul_a = ext_ff[0]; mul_b = ext_ff[1]; end
         end
         default: mul_neg = 1'b0;
      endcase
   end

   assign prod_s = $signed({2'b00, prod_ff});
   assign dmag   = d_ff[PROD_W+1] ? $unsigned(-d_ff) : $unsigned(d_ff);

   // multiply, then combine products into cross terms, sums of squares and the quad area
   always_ff @(posedge clock) begin
      prod_ff     <= mul_a * mul_b;
      prod_neg_ff <= mul_neg;
      case (cmd.acc_op)
         ACC_SS_LOAD:    ss_ff <= prod_ff;
         ACC_SS_ADD:     ss_ff <= ss_ff + prod_ff;
         ACC_CROSS_LOAD: cacc_ff <= prod_neg_ff ? -prod_s : prod_s;
         ACC_CROSS_SUB:  d_ff <= prod_neg_ff ? cacc_ff + prod_s : cacc_ff - prod_s;
         ACC_QUAD: begin
            quad_sat_ff  <= |prod_ff[PROD_W-1:47];
            quad_area_ff <= (|prod_ff[PROD_W-1:47]) ? POS_MAX[COORD_W-2:0]
                                                    : prod_ff[46:16];
         end
         default: ss_ff <= ss_ff;
      endcase
      if (cmd.cvt) begin
         h_neg_ff[cmd.cvt_idx] <= d_ff[PROD_W+1];
         h_mag_ff[cmd.cvt_idx] <= dmag[64:17];
      end
   end

   // square root step operands
   assign rem2  = {sq_rem_ff, rad_ff[PROD_W-1:PROD_W-2]};
   assign trial = {2'b00, root_ff, 2'b01};

   always_comb begin
      for (int j = 0; j < SPACE_DIMS; j++) begin
         dtmp[j] = {rem_ff[j], q_ff[j][SUM_W-1]};
      end
   end

   // center divider lanes and square root, one bit per cycle while their step command is set
   always_ff @(posedge clock) begin
      if (cmd.root_load) begin
         for (int j = 0; j < SPACE_DIMS; j++) begin
            s_neg_ff[j] <= sum_ff[j][SUM_W-1];
            q_ff[j]     <= sum_ff[j][SUM_W-1] ? $unsigned(-sum_ff[j]) : $unsigned(sum_ff[j]);
            rem_ff[j]   <= '0;
         end
         rad_ff    <= ss_ff;
         sq_rem_ff <= '0;
         root_ff   <= '0;
      end else begin
         if (cmd.div_step) begin
            for (int j = 0; j < SPACE_DIMS; j++) begin
               if (dtmp[j] >= count_ff) begin
                  rem_ff[j] <= 2'(dtmp[j] - count_ff);
                  q_ff[j]   <= {q_ff[j][SUM_W-2:0], 1'b1};
               end else begin
                  rem_ff[j] <= dtmp[j][1:0];
                  q_ff[j]   <= {q_ff[j][SUM_W-2:0], 1'b0};
               end
            end
         end
         if (cmd.sqrt_step) begin
            if (rem2 >= trial) begin
               sq_rem_ff <= 34'(rem2 - trial);
               root_ff   <= {root_ff[COORD_W-2:0], 1'b1};
            end else begin
               sq_rem_ff <= rem2[33:0];
               root_ff   <= {root_ff[COORD_W-2:0], 1'b0};
            end
            rad_ff <= {rad_ff[PROD_W-3:0], 2'b00};
         end
      end
   end

   // build the result item
   always_comb begin
      logic [COORD_W:0]   nv [SPACE_DIMS];
      logic [SUM_W-1:0]   cv [SPACE_DIMS];
      logic               big;
      logic               sat;
      logic [COORD_W-2:0] root_area;
      for (int j = 0; j < SPACE_DIMS; j++) begin
         nv[j] = '0;
         cv[j] = s_neg_ff[j] ? (SUM_W'(0) - q_ff[j]) : q_ff[j];
      end
      big       = 1'b0;
      sat       = 1'b0;
      root_area = root_ff[COORD_W-2:0];
      result    = '0;
      result.center_x = cv[0][COORD_W-1:0];
      result.center_y = cv[1][COORD_W-1:0];
      result.center_z = cv[2][COORD_W-1:0];
      case (kind_ff)
         KIND_EDGE: begin
            big   = va_mag_ff[0][COORD_W-1] | va_mag_ff[1][COORD_W-1];
            nv[0] = sat_sm(va_neg_ff[1], HMAG_W'(va_mag_ff[1]));
            nv[1] = sat_sm(!va_neg_ff[0], HMAG_W'(va_mag_ff[0]));
            if (big || root_ff[COORD_W-1]) begin
               root_area = POS_MAX[COORD_W-2:0];
               sat       = 1'b1;
            end
            result.area = root_area;
         end
         KIND_TRI: begin
            for (int j = 0; j < SPACE_DIMS; j++) begin
               big   = big | (|h_mag_ff[j][HMAG_W-1:COORD_W-1]);
               nv[j] = sat_sm(h_neg_ff[j], h_mag_ff[j]);
            end
            if (big || root_ff[COORD_W-1]) begin
               root_area = POS_MAX[COORD_W-2:0];
               sat       = 1'b1;
            end
            result.area = root_area;
         end
         KIND_QUAD: begin
            if (flat != '0) begin
               result.area = quad_area_ff;
               sat         = quad_sat_ff;
               if (flat[0]) nv[0] = {2'b00, quad_area_ff};
               else if (flat[1]) nv[1] = {2'b00, quad_area_ff};
               else nv[2] = {2'b00, quad_area_ff};
            end
         end
         default: begin
            result.center_x = '0;
            result.center_y = '0;
            result.center_z = '0;
         end
      endcase
      for (int j = 0; j < SPACE_DIMS; j++) sat = sat | nv[j][COORD_W];
      result.normal_x = nv[0][COORD_W-1:0];
      result.normal_y = nv[1][COORD_W-1:0];
      result.normal_z = nv[2][COORD_W-1:0];
      if (kind_ff == KIND_ERR) result.shape_error = SHAPE_BAD;
      else if (sat) result.shape_error = SHAPE_SAT;
      else result.shape_error = SHAPE_OK;
   end

endmodule
